// ===== hdl/depth_sorted_insert_buffer_top_defines.svh =====
// Assertion macros for the depth-sorted insertion buffer.
`ifndef DEPTH_SORTED_INSERT_BUFFER_TOP_DEFINES_SVH
`define DEPTH_SORTED_INSERT_BUFFER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define DSIB_ASSERT_IMPL(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DSIB_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define DSIB_ASSERT_IMPL(label, prop, msg)
`define DSIB_ASSERT_NEVER(label, expr, msg)
`endif
`endif

// ===== hdl/dsib_pkg.sv =====
// Shared constants and types of the depth-sorted insertion buffer.
`timescale 1ns / 1ps
package dsib_pkg;
    localparam int CAPACITY_DEF = 256;
    localparam int ID_BITS_DEF  = 16;
    localparam int KEY_BITS     = 32;
    localparam int RANK_BITS    = 8;
    localparam int CNT_OUT_BITS = 9;

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    typedef struct packed {
        logic we;
        logic re;
    } mem_ctl_t;
endpackage

// ===== hdl/dsib_store.sv =====
// Entry store: one synchronous memory of biased keys and ids.
`timescale 1ns / 1ps
module dsib_store #(
    parameter int CAPACITY = dsib_pkg::CAPACITY_DEF,
    parameter int ID_BITS  = dsib_pkg::ID_BITS_DEF,
    localparam int AW      = $clog2(CAPACITY),
    localparam int DW      = dsib_pkg::KEY_BITS + ID_BITS
) (
    input  logic                clk,
    input  dsib_pkg::mem_ctl_t  ctl,
    input  logic [AW-1:0]       waddr,
    input  logic [DW-1:0]       wdata,
    input  logic [AW-1:0]       raddr,
    output logic [DW-1:0]       rdata
);
    logic [DW-1:0] mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[waddr] <= wdata;
        end
        if (ctl.re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== hdl/depth_sorted_insert_buffer_top.sv =====
// Top level of the depth-sorted insertion buffer: sequencer around the entry store.
//
// Requests arrive on the in channel (in_valid / in_stall): clear, insert or read.
// Each request gives exactly one result on the out channel (out_valid / out_stall).
// Clear, an unknown type and a read at or beyond the count go straight to the
// output register; a read that hits does one store read. An insert into an
// empty list writes its entry without a search. Any other insert runs a binary
// search of up to log2(CAPACITY)+1 store reads, then opens its slot by shifting
// one side, one entry at a time (read then write on the single store port pair).
// A full store shifts up to CAPACITY-1 entries; append and prepend skip the shift.
// One request is worked at a time; in_stall is high while busy or while a
// result waits in the output register. The result register holds while
// out_stall is high, and the next request is accepted once it is taken.
// Reset empties the list (both bounds at CAPACITY/2); the store contents are
// left undefined and are never read before being written.
`timescale 1ns / 1ps
`include "depth_sorted_insert_buffer_top_defines.svh"
module depth_sorted_insert_buffer_top #(
    parameter int CAPACITY = dsib_pkg::CAPACITY_DEF,
    parameter int ID_BITS  = dsib_pkg::ID_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          req_type,
    input  logic signed [31:0]  depth_key,
    input  logic [15:0]         object_id,
    input  logic [7:0]          read_rank,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  entry_key,
    output logic [15:0]         entry_id,
    output logic                entry_valid,
    output logic [8:0]          insert_rank,
    output logic [8:0]          entry_count,
    output logic                was_dropped,
    output logic                was_evicted
);
    localparam int AW = $clog2(CAPACITY);
    localparam int BW = AW + 1;
    localparam int KB = dsib_pkg::KEY_BITS;
    localparam int DW = KB + ID_BITS;
    localparam logic [BW-1:0] HALF = BW'(CAPACITY / 2);
    localparam logic [BW-1:0] CAP  = BW'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH, S_SRCHW, S_DECIDE, S_SHRD, S_SHWR, S_PUT, S_RDW, S_RDD, S_OUT
    } state_t;

    state_t         state_reg;
    logic [BW-1:0]  low_reg, high_reg, lo_reg, hi_reg, idx_reg, ptr_reg;
    logic [KB-1:0]  bkey_reg;
    logic [ID_BITS-1:0] id_reg;
    logic           left_reg;
    logic [7:0]     rank_reg;
    logic           ov_reg;
    logic signed [31:0] ok_reg;
    logic [15:0]    oid_reg;
    logic           oval_reg, odrop_reg, oev_reg;
    logic [8:0]     orank_reg;

    dsib_pkg::mem_ctl_t ctl;
    logic [AW-1:0]  waddr, raddr;
    logic [DW-1:0]  wdata, rdata;

    dsib_store #(.CAPACITY(CAPACITY), .ID_BITS(ID_BITS)) u_store (
        .clk(clk), .ctl(ctl), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    logic [BW-1:0] mid;
    logic [KB-1:0] rkey;
    assign mid  = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign rkey = rdata[DW-1:ID_BITS];

    always_comb
    begin
        ctl   = '0;
        waddr = '0;
        wdata = {bkey_reg, id_reg};
        raddr = '0;
        unique case (state_reg)
            S_SRCH:
            begin
                ctl.re = 1'b1;
                raddr  = mid[AW-1:0];
            end
            S_SHRD:
            begin
                ctl.re = 1'b1;
                raddr  = left_reg ? ptr_reg[AW-1:0] : AW'(ptr_reg - 1'b1);
            end
            S_SHWR:
            begin
                ctl.we = 1'b1;
                waddr  = left_reg ? AW'(ptr_reg - 1'b1) : ptr_reg[AW-1:0];
                wdata  = rdata;
            end
            S_PUT:
            begin
                ctl.we = 1'b1;
                waddr  = idx_reg[AW-1:0];
            end
            S_RDW:
            begin
                ctl.re = 1'b1;
                raddr  = AW'(low_reg + BW'(rank_reg));
            end
            default:
            begin
            end
        endcase
    end

    logic [BW-1:0] cnt;
    assign cnt = high_reg - low_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            low_reg   <= HALF;
            high_reg  <= HALF;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (ov_reg && !out_stall && state_reg != S_OUT)
            begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        bkey_reg  <= {~depth_key[31], depth_key[30:0]};
                        id_reg    <= ID_BITS'(object_id);
                        rank_reg  <= read_rank;
                        ok_reg    <= '0;
                        oid_reg   <= '0;
                        oval_reg  <= 1'b0;
                        odrop_reg <= 1'b0;
                        oev_reg   <= 1'b0;
                        orank_reg <= '0;
                        lo_reg    <= low_reg;
                        hi_reg    <= high_reg;
                        unique case (req_type)
                            dsib_pkg::REQ_CLEAR:
                            begin
                                low_reg   <= HALF;
                                high_reg  <= HALF;
                                state_reg <= S_OUT;
                            end
                            dsib_pkg::REQ_INSERT:
                            begin
                                if (low_reg >= high_reg)
                                begin
                                    low_reg   <= HALF;
                                    high_reg  <= HALF + 1'b1;
                                    idx_reg   <= HALF;
                                    state_reg <= S_PUT;
                                end
                                else
                                begin
                                    state_reg <= S_SRCH;
                                end
                            end
                            dsib_pkg::REQ_READ:
                            begin
                                state_reg <= (BW'(read_rank) < cnt) ? S_RDW : S_OUT;
                            end
                            default:
                            begin
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_SRCH:
                begin
                    idx_reg   <= mid;
                    state_reg <= S_SRCHW;
                end
                S_SRCHW:
                begin
                    if (bkey_reg < rkey)
                    begin
                        hi_reg <= idx_reg;
                        state_reg <= (lo_reg < idx_reg) ? S_SRCH : S_DECIDE;
                    end
                    else
                    begin
                        lo_reg <= idx_reg + 1'b1;
                        state_reg <= (idx_reg + 1'b1 < hi_reg) ? S_SRCH : S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    logic noleft, norite, gl;
                    logic [BW-1:0] hb;
                    noleft = (low_reg == '0);
                    norite = (high_reg >= CAP);
                    hb     = high_reg;
                    idx_reg <= lo_reg;
                    orank_reg <= 9'(lo_reg - low_reg);
                    if (noleft && norite)
                    begin
                        if (lo_reg == high_reg)
                        begin
                            odrop_reg <= 1'b1;
                            orank_reg <= '0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            hb = high_reg - 1'b1;
                            oev_reg   <= 1'b1;
                            left_reg  <= 1'b0;
                            ptr_reg   <= hb;
                            high_reg  <= hb + 1'b1;
                            state_reg <= (hb > lo_reg) ? S_SHRD : S_PUT;
                        end
                    end
                    else if (!norite && lo_reg == high_reg)
                    begin
                        high_reg  <= high_reg + 1'b1;
                        state_reg <= S_PUT;
                    end
                    else if (!noleft && lo_reg == low_reg)
                    begin
                        idx_reg   <= lo_reg - 1'b1;
                        low_reg   <= low_reg - 1'b1;
                        state_reg <= S_PUT;
                    end
                    else
                    begin
                        gl = norite || ((lo_reg - low_reg) <= (hb - lo_reg) && !noleft);
                        left_reg <= gl;
                        if (gl)
                        begin
                            ptr_reg   <= low_reg;
                            low_reg   <= low_reg - 1'b1;
                            idx_reg   <= lo_reg - 1'b1;
                        end
                        else
                        begin
                            ptr_reg   <= hb;
                            high_reg  <= hb + 1'b1;
                        end
                        state_reg <= S_SHRD;
                    end
                end
                S_SHRD:
                begin
                    state_reg <= S_SHWR;
                end
                S_SHWR:
                begin
                    if (left_reg)
                    begin
                        ptr_reg   <= ptr_reg + 1'b1;
                        state_reg <= (ptr_reg + 1'b1 < idx_reg + 1'b1) ? S_SHRD : S_PUT;
                    end
                    else
                    begin
                        ptr_reg   <= ptr_reg - 1'b1;
                        state_reg <= (ptr_reg - 1'b1 > idx_reg) ? S_SHRD : S_PUT;
                    end
                end
                S_PUT:
                begin
                    state_reg <= S_OUT;
                end
                S_RDW:
                begin
                    state_reg <= S_RDD;
                end
                S_RDD:
                begin
                    ok_reg    <= {~rkey[KB-1], rkey[KB-2:0]};
                    oid_reg   <= 16'(rdata[ID_BITS-1:0]);
                    oval_reg  <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!ov_reg || !out_stall)
                    begin
                        ov_reg    <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall    = (state_reg != S_IDLE) || (ov_reg && out_stall);
    assign out_valid   = ov_reg;
    assign entry_key   = ok_reg;
    assign entry_id    = oid_reg;
    assign entry_valid = oval_reg;
    assign insert_rank = orank_reg;
    assign entry_count = 9'(cnt);
    assign was_dropped = odrop_reg;
    assign was_evicted = oev_reg;

    `DSIB_ASSERT_NEVER(a_bounds, low_reg > high_reg, "low bound above high bound")
    `DSIB_ASSERT_NEVER(a_cap, high_reg > CAP, "high bound beyond capacity")
    `DSIB_ASSERT_NEVER(a_flags, ov_reg && was_dropped && was_evicted, "drop and evict together")
    `DSIB_ASSERT_IMPL(a_busy, (state_reg != S_IDLE) |-> in_stall, "request taken while busy")
endmodule

// ===== test/dsib_checker.sv =====
// Checker for the depth-sorted insertion buffer: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module dsib_checker #(
    parameter int CAPACITY = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic signed [31:0] depth_key,
    input  logic [15:0]        object_id,
    input  logic [7:0]         read_rank,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] entry_key,
    input  logic [15:0]        entry_id,
    input  logic               entry_valid,
    input  logic [8:0]         insert_rank,
    input  logic [8:0]         entry_count,
    input  logic               was_dropped,
    input  logic               was_evicted,
    output int                 mismatches,
    output int                 pending,
    output int                 inserts_seen,
    output int                 evictions_seen,
    output int                 drops_seen
);
    typedef struct packed {
        logic signed [31:0] key;
        logic [15:0]        id;
        logic               valid;
        logic [8:0]         rank;
        logic [8:0]         count;
        logic               dropped;
        logic               evicted;
    } entry_result_t;

    logic signed [31:0] keys [CAPACITY];
    logic [15:0]        ids [CAPACITY];
    int                 lo_b;
    int                 hi_b;
    entry_result_t      expected_q [$];

    function automatic entry_result_t sort_and_place(logic [1:0] req, logic signed [31:0] k,
                                                     logic [15:0] id, logic [7:0] rk);
        entry_result_t r;
        int            idx, lo, hi, mid, old_low;
        bit            noleft, norite, keep, shift, go_left;
        r = '0;
        if (req == dsib_pkg::REQ_CLEAR) begin
            lo_b = CAPACITY / 2;
            hi_b = CAPACITY / 2;
        end else if (req == dsib_pkg::REQ_INSERT) begin
            noleft = (lo_b == 0);
            norite = (hi_b >= CAPACITY);
            if (lo_b >= hi_b) begin
                lo_b = CAPACITY / 2;
                hi_b = lo_b + 1;
                keys[lo_b] = k;
                ids[lo_b] = id;
            end else begin
                lo = lo_b;
                hi = hi_b;
                while (lo < hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (k < keys[mid])
                        hi = mid;
                    else
                        lo = mid + 1;
                end
                idx = lo;
                old_low = lo_b;
                keep = 1;
                shift = 0;
                if (noleft && norite) begin
                    if (idx == hi_b) begin
                        keep = 0;
                        r.dropped = 1;
                    end else begin
                        hi_b--;
                        r.evicted = 1;
                        norite = 0;
                        shift = 1;
                    end
                end else if (!norite && idx == hi_b) begin
                    keys[idx] = k;
                    ids[idx] = id;
                    hi_b++;
                end else if (!noleft && idx == lo_b) begin
                    keys[idx - 1] = k;
                    ids[idx - 1] = id;
                    lo_b--;
                end else begin
                    shift = 1;
                end
                if (shift) begin
                    go_left = norite || ((idx - lo_b) <= (hi_b - idx) && !noleft);
                    if (go_left) begin
                        for (int i = lo_b; i < idx; i++) begin
                            keys[i - 1] = keys[i];
                            ids[i - 1] = ids[i];
                        end
                        lo_b--;
                        keys[idx - 1] = k;
                        ids[idx - 1] = id;
                    end else begin
                        for (int i = hi_b; i > idx; i--) begin
                            if (i < CAPACITY) begin
                                keys[i] = keys[i - 1];
                                ids[i] = ids[i - 1];
                            end
                        end
                        hi_b++;
                        keys[idx] = k;
                        ids[idx] = id;
                    end
                end
                if (keep)
                    r.rank = 9'(idx - old_low);
            end
        end else if (req == dsib_pkg::REQ_READ) begin
            if (int'(rk) < hi_b - lo_b && lo_b + int'(rk) < CAPACITY) begin
                r.key = keys[lo_b + int'(rk)];
                r.id = ids[lo_b + int'(rk)];
                r.valid = 1;
            end
        end
        r.count = 9'(hi_b - lo_b);
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        entry_result_t e, a;
        if (!rst_n) begin
            lo_b = CAPACITY / 2;
            hi_b = CAPACITY / 2;
            expected_q = {};
            mismatches <= 0;
            inserts_seen <= 0;
            evictions_seen <= 0;
            drops_seen <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                a = '{entry_key, entry_id, entry_valid, insert_rank, entry_count,
                      was_dropped, was_evicted};
                if (expected_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result %p", a);
                    mismatches <= mismatches + 1;
                end else begin
                    e = expected_q.pop_front();
                    if (e.dropped)
                        drops_seen <= drops_seen + 1;
                    if (e.evicted)
                        evictions_seen <= evictions_seen + 1;
                    if (a !== e) begin
                        if (mismatches < 10)
                            $display("mismatch: expected %p, got %p", e, a);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (in_valid && !in_stall) begin
                if (req_type == dsib_pkg::REQ_INSERT)
                    inserts_seen <= inserts_seen + 1;
                expected_q.push_back(sort_and_place(req_type, depth_key, object_id, read_rank));
            end
        end
    end
endmodule

// ===== test/tb_depth_sorted_insert_buffer_top.sv =====
// Testbench top for the depth-sorted insertion buffer: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_depth_sorted_insert_buffer_top;
    localparam int CAP = 256;
    localparam int STALL_LIMIT = 5000;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         req_type;
    logic signed [31:0] depth_key;
    logic [15:0]        object_id;
    logic [7:0]         read_rank;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] entry_key;
    logic [15:0]        entry_id;
    logic               entry_valid;
    logic [8:0]         insert_rank;
    logic [8:0]         entry_count;
    logic               was_dropped;
    logic               was_evicted;
    int                 mismatches;
    int                 pending;
    int                 inserts_seen;
    int                 evictions_seen;
    int                 drops_seen;
    int                 quiet_cycles;
    bit                 calm;
    int                 requests_sent;

    depth_sorted_insert_buffer_top #(.CAPACITY(CAP)) dut (.*);

    dsib_checker #(.CAPACITY(CAP)) u_checker (.*);

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= !calm && ($urandom_range(99) < 8);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("tb_depth_sorted_insert_buffer_top NOT OK");
            $finish;
        end
    end

    task automatic send_request(logic [1:0] req, logic signed [31:0] k, logic [15:0] id,
                                logic [7:0] rk);
        while (!calm && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        depth_key <= k;
        object_id <= id;
        read_rank <= rk;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        requests_sent++;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_key(int spread);
        case ($urandom_range(5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $urandom;
            default: return 32'(int'($urandom_range(2 * spread)) - spread);
        endcase
    endfunction

    initial
    begin
        int n;
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = dsib_pkg::REQ_CLEAR;
        depth_key = '0;
        object_id = '0;
        read_rank = '0;
        calm = 1'b0;
        requests_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(dsib_pkg::REQ_READ, 0, 0, 0);
        send_request(dsib_pkg::REQ_INSERT, 32'sh7fff_ffff, 16'hffff, 0);
        send_request(dsib_pkg::REQ_INSERT, 32'sh8000_0000, 16'h0000, 0);
        send_request(dsib_pkg::REQ_INSERT, 5, 16'h0001, 0);
        send_request(dsib_pkg::REQ_INSERT, 5, 16'h0002, 0);
        send_request(dsib_pkg::REQ_INSERT, 5, 16'h0003, 0);
        send_request(dsib_pkg::REQ_INSERT, -7, 16'h5555, 0);
        send_request(dsib_pkg::REQ_INSERT, 100, 16'haaaa, 0);
        for (int r = 0; r < 9; r++)
            send_request(dsib_pkg::REQ_READ, 0, 0, 8'(r));
        send_request(dsib_pkg::REQ_READ, 0, 0, 8'hff);
        send_request(REQ_UNUSED, 32'sh1234_5678, 16'h1234, 8'h12);
        send_request(dsib_pkg::REQ_CLEAR, 0, 0, 0);
        send_request(dsib_pkg::REQ_READ, 0, 0, 0);
        drain();

        for (int phase = 0; phase < 2; phase++)
        begin
            calm = (phase == 1);
            send_request(dsib_pkg::REQ_CLEAR, 0, 0, 0);
            n = 0;
            while (n < 370)
            begin
                send_request(dsib_pkg::REQ_INSERT, pick_key(phase == 1 ? 200 : 4000),
                             16'($urandom), 0);
                n++;
                if ($urandom_range(9) == 0)
                begin
                    send_request(dsib_pkg::REQ_READ, 0, 0, 8'($urandom));
                    n++;
                end
            end
            for (int r = 0; r < 20; r++)
                send_request($urandom_range(9) == 0 ? REQ_UNUSED : dsib_pkg::REQ_READ,
                             $urandom, 16'($urandom), 8'($urandom));
            drain();
        end
        calm = 1'b0;

        repeat (60)
        begin
            send_request(2'($urandom_range(3)), pick_key(50), 16'($urandom), 8'($urandom_range(70)));
        end
        drain();
        repeat (20) @(posedge clk);

        $display("Sent %0d requests, %0d inserts, %0d evictions, %0d drops from a full store.",
                 requests_sent, inserts_seen, evictions_seen, drops_seen);
        if (mismatches == 0)
            $display("tb_depth_sorted_insert_buffer_top OK");
        else
            $display("tb_depth_sorted_insert_buffer_top NOT OK");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/dsib_pkg.sv
hdl/dsib_store.sv
hdl/depth_sorted_insert_buffer_top.sv
test/dsib_checker.sv
test/tb_depth_sorted_insert_buffer_top.sv
